>>> src/pfba_pkg.sv
`timescale 1ns / 1ps

package pfba_pkg;

    // Map geometry
    localparam int TOTAL_PAGES = 512;
    localparam int WORD_BITS   = 32;
    localparam int MAP_WORDS   = (TOTAL_PAGES + WORD_BITS - 1) / WORD_BITS;
    localparam int WIDX_W      = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W       = $clog2(WORD_BITS);
    localparam int COUNT_W     = $clog2(TOTAL_PAGES + 1);

    // Field widths
    localparam int OP_W        = 2;
    localparam int PAGE_W      = 9;
    localparam int STATUS_W    = 2;
    localparam int FREE_W      = 10;
    localparam int CFG_W       = 10;
    localparam int IN_TDATA_W  = 16;
    localparam int OUT_TDATA_W = 24;

    typedef enum logic [OP_W-1:0] {
        OP_ALLOC   = 2'd0,
        OP_FREE    = 2'd1,
        OP_REBUILD = 2'd2,
        OP_NOP     = 2'd3
    } t_opcode;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2,
        ST_ALREADY = 2'd3
    } t_status;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;
        logic scan;
        logic exec;
        logic out_load;
    } t_dp_cmd;

    // Status from datapath to controller
    typedef struct packed {
        t_opcode in_op;
        logic    hit;
        logic    last;
    } t_dp_sts;

    // Free bits of map word w after a rebuild starting at page start
    function automatic logic [WORD_BITS-1:0] map_word(input int w,
                                                      input logic [CFG_W-1:0] start);
        logic [WORD_BITS-1:0] word;
        int                   p;
        word = '0;
        for (int b = 0; b < WORD_BITS; b++) begin
            p = w * WORD_BITS + b;
            word[b] = (p >= int'(start)) && (p < TOTAL_PAGES);
        end
        return word;
    endfunction

    // Free page count after a rebuild starting at page start
    function automatic logic [COUNT_W-1:0] rebuild_total(input logic [CFG_W-1:0] start);
        logic [COUNT_W-1:0] cnt;
        if (int'(start) < TOTAL_PAGES) begin
            cnt = COUNT_W'(TOTAL_PAGES - int'(start));
        end else begin
            cnt = '0;
        end
        return cnt;
    endfunction

endpackage

>>> src/pfba_ctrl.sv
`timescale 1ns / 1ps

module pfba_ctrl
    import pfba_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    output logic    o_out_valid,
    input  logic    i_out_ready,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_EXEC,
        S_HOLD
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_acc;
    logic   out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign in_acc      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;

    // Sequence one item: capture, scan or execute, then load the output register
    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        o_cmd       = '0;
        unique case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    o_cmd.capture = 1'b1;
                    n_state = (i_sts.in_op == OP_ALLOC) ? S_SCAN : S_EXEC;
                end
            end
            S_SCAN: begin
                o_cmd.scan = 1'b1;
                if (i_sts.hit || i_sts.last) begin
                    n_state = S_HOLD;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = S_HOLD;
            end
            S_HOLD: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Hold state and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

>>> src/pfba_dp.sv
`timescale 1ns / 1ps

module pfba_dp
    import pfba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [CFG_W-1:0]       i_cfg_wdata,
    input  logic [IN_TDATA_W-1:0]  i_in_data,
    output logic [OUT_TDATA_W-1:0] o_out_data,
    input  t_dp_cmd                i_cmd,
    output t_dp_sts                o_sts
);

    logic [WORD_BITS-1:0]   r_map [MAP_WORDS];
    logic [COUNT_W-1:0]     r_total;
    logic [CFG_W-1:0]       r_first;
    t_opcode                r_op;
    logic [PAGE_W-1:0]      r_page;
    logic [WIDX_W-1:0]      r_idx;
    logic [PAGE_W-1:0]      r_res_page;
    t_status                r_res_status;
    logic [OUT_TDATA_W-1:0] r_out_data;

    logic [WORD_BITS-1:0]   cur_word;
    logic [BIT_W-1:0]       low_bit;
    logic                   hit;
    logic                   last;
    logic [WIDX_W-1:0]      f_idx;
    logic [BIT_W-1:0]       f_bit;
    logic                   f_in_range;
    logic                   f_is_free;

    // Examine the word under the scan pointer
    assign cur_word = r_map[r_idx];
    assign hit      = |cur_word;
    assign last     = (r_idx == WIDX_W'(MAP_WORDS - 1));

    // Lowest set bit of the current word
    always_comb begin
        low_bit = '0;
        for (int b = WORD_BITS - 1; b >= 0; b--) begin
            if (cur_word[b]) begin
                low_bit = BIT_W'(b);
            end
        end
    end

    // Locate the page to release
    assign f_idx      = WIDX_W'(r_page >> BIT_W);
    assign f_bit      = r_page[BIT_W-1:0];
    assign f_in_range = 32'(r_page) < 32'(TOTAL_PAGES);
    assign f_is_free  = r_map[f_idx][f_bit];

    assign o_sts.in_op = t_opcode'(i_in_data[OP_W-1:0]);
    assign o_sts.hit   = hit;
    assign o_sts.last  = last;
    assign o_out_data  = r_out_data;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int w = 0; w < MAP_WORDS; w++) begin
                r_map[w] <= map_word(w, '0);
            end
            r_total <= rebuild_total('0);
            r_first <= '0;
        end else begin
            if (i_cfg_wen) begin
                r_first <= i_cfg_wdata;
            end

            // Latch the item and rewind the scan pointer
            if (i_cmd.capture) begin
                r_op   <= t_opcode'(i_in_data[OP_W-1:0]);
                r_page <= i_in_data[OP_W +: PAGE_W];
                r_idx  <= '0;
            end

            // Scan one word: grant its lowest free page, or advance
            if (i_cmd.scan) begin
                if (hit) begin
                    r_map[r_idx][low_bit] <= 1'b0;
                    if (r_total != '0) begin
                        r_total <= r_total - COUNT_W'(1);
                    end
                    r_res_page   <= PAGE_W'({r_idx, low_bit});
                    r_res_status <= ST_OK;
                end else if (last) begin
                    r_res_page   <= '0;
                    r_res_status <= ST_NO_FREE;
                end else begin
                    r_idx <= r_idx + WIDX_W'(1);
                end
            end

            // Free, rebuild or no operation
            if (i_cmd.exec) begin
                r_res_page <= '0;
                unique case (r_op)
                    OP_FREE: begin
                        if (!f_in_range) begin
                            r_res_status <= ST_RANGE;
                        end else if (f_is_free) begin
                            r_res_status <= ST_ALREADY;
                        end else begin
                            r_map[f_idx][f_bit] <= 1'b1;
                            r_total      <= r_total + COUNT_W'(1);
                            r_res_status <= ST_OK;
                        end
                    end
                    OP_REBUILD: begin
                        for (int w = 0; w < MAP_WORDS; w++) begin
                            r_map[w] <= map_word(w, r_first);
                        end
                        r_total      <= rebuild_total(r_first);
                        r_res_status <= ST_OK;
                    end
                    OP_ALLOC, OP_NOP: begin
                        r_res_status <= ST_OK;
                    end
                    default: begin
                        r_res_status <= ST_OK;
                    end
                endcase
            end

            // Pack the result item
            if (i_cmd.out_load) begin
                r_out_data <= OUT_TDATA_W'({FREE_W'(r_total), r_res_status, r_res_page});
            end
        end
    end

endmodule

>>> src/page_frame_bitmap_allocator.sv
`timescale 1ns / 1ps
// Free, rebuild and no-op: the item is captured and executed, then the result waits to load.
// Allocate: the item is captured, then the free map is scanned word by word from word 0 up to
// the first nonzero word (index 0..15), or to the last word if none is free; the result then
// waits for the output register. A new item is taken only after the last result is loaded.
// Reset (synchronous, active low): every page free, count 512, first_free_page 0.

module page_frame_bitmap_allocator
    import pfba_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wen,
    input  logic [CFG_W-1:0]       i_cfg_wdata,   // first_free_page
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,  // [1:0] opcode, [10:2] page_number
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [8:0] allocated_page, [10:9] status,
                                                  // [20:11] free_pages
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    pfba_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    pfba_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_wen   (i_cfg_wen),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in_data   (s_axis_tdata),
        .o_out_data  (m_axis_tdata),
        .i_cmd       (cmd),
        .o_sts       (sts)
    );

endmodule

>>> src/pfba_checker.sv
`timescale 1ns / 1ps

module pfba_checker
    import pfba_pkg::*;
(
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // Stalled result item holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result item changed while stalled");

    // One item at a time: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("second item taken while busy");

    // Count never exceeds the number of pages
    a_count_max: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> 32'(m_axis_tdata[20:11]) <= 32'(TOTAL_PAGES))
        else $error("free page count out of range");

    // A granted page comes only with ok status
    a_grant_ok: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[8:0] != '0) |-> m_axis_tdata[10:9] == ST_OK)
        else $error("page granted with failing status");

    // Allocation fails only with nothing free
    a_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && (m_axis_tdata[10:9] == ST_NO_FREE) |-> m_axis_tdata[20:11] == '0)
        else $error("allocation failed with free pages left");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (.*);
